@@ rtl/blir_pkg.sv @@
`default_nettype none

package blir_pkg;

    // Fixed field widths of the request, response and configuration items.
    localparam int MODE_BITS  = 3;
    localparam int POS_BITS   = 5;
    localparam int VALUE_BITS = 32;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 5;
    localparam int CAP_BITS   = 5;

    // Wide enough to name any cell of the largest supported chain.
    localparam int IDX_BITS = 8;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_SET    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic                  accepted;
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] count;
        logic                  is_full;
        logic                  is_empty;
    } t_rsp;

    typedef logic [CAP_BITS-1:0] t_cfg;

    typedef enum logic [1:0] {
        CELL_NONE,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op            op;
        logic [IDX_BITS-1:0] idx;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/blir_chan_if.sv @@
`default_nettype none

interface blir_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/blir_cell.sv @@
`default_nettype none

// One entry of the list. It loads a new word, takes its left neighbor's word
// when the list opens a gap below it, or its right neighbor's word when the
// list closes one.
module blir_cell #(
    parameter int IDX       = 0,
    parameter int WORD_BITS = 32
) (
    input  wire                       i_clk,
    input  wire  blir_pkg::t_cell_cmd i_cmd,
    input  wire  [WORD_BITS-1:0]      i_word,
    input  wire  [WORD_BITS-1:0]      i_left,
    input  wire  [WORD_BITS-1:0]      i_right,
    output logic [WORD_BITS-1:0]      o_word
);
    import blir_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            CELL_WRITE: begin
                if (MY_IDX == i_cmd.idx) begin
                    n_word = i_word;
                end
            end
            CELL_INSERT: begin
                if (MY_IDX == i_cmd.idx) begin
                    n_word = i_word;
                end else if (MY_IDX > i_cmd.idx) begin
                    n_word = i_left;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_cmd.idx) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

@@ rtl/bounded_list_insert_remove_unit.sv @@
`default_nettype none

// Bounded ordered list of data words, held in a chain of DEPTH cells.
//
// Channels: i_req carries one request item (mode, position, value), o_rsp one
// response item (accepted, data, count, is_full, is_empty) for every request,
// and i_cfg writes the capacity register. All use valid/ready; an item moves
// on a rising edge where both are high. i_cfg is always ready and must only
// be written while no request is in flight.
//
// Timing: each request takes effect at the edge that accepts it. Insert and
// remove shift the entries above the position (insert: also the one at it)
// by one cell, so the chain of cells sets the rate: one item per cycle while i_req.ready is high.
//
// Stalls: the response register is backed by a one-item skid register, so a
// request is still accepted while a finished response waits. i_req.ready
// drops only when both are full.
//
// Reset (i_rst_n low, synchronous) empties the list, sets capacity to 16 and
// drops any pending response. Entry words are not cleared.
module bounded_list_insert_remove_unit #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input wire          i_clk,
    input wire          i_rst_n,
    blir_chan_if.sink   i_req,
    blir_chan_if.source o_rsp,
    blir_chan_if.sink   i_cfg
);
    import blir_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    // Common compare width for count, position and capacity.
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;
    // Common width for moving words between the ports and the cells.
    localparam int XW = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam logic [PW-1:0] DEPTH_X = PW'(DEPTH);

    // Control state.
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CAP_BITS-1:0] r_cap;
    logic                r_out_valid;
    logic                r_skid_valid;

    // Response payload registers.
    t_rsp r_out;
    t_rsp r_skid;

    // Cell chain.
    t_cell_cmd            cell_cmd;
    logic [WORD_BITS-1:0] cell_q [DEPTH];
    logic [WORD_BITS-1:0] in_word;
    logic [WORD_BITS-1:0] rd_word;

    logic [XW-1:0] value_x;
    logic [XW-1:0] rd_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cap_x;
    logic [PW-1:0] cnt_new_x;
    logic          room;
    logic          in_range;
    logic          ok;
    logic          accept;
    logic          out_take;
    t_rsp          rsp_new;

    assign accept   = i_req.valid && i_req.ready;
    assign out_take = r_out_valid && o_rsp.ready;

    assign i_req.ready = !r_skid_valid;
    assign i_cfg.ready = 1'b1;

    assign value_x = XW'(i_req.data.value);
    assign in_word = value_x[WORD_BITS-1:0];

    assign cnt_x = PW'(r_count);
    assign pos_x = PW'(i_req.data.position);
    // Capacity above the chain length saturates to the chain length.
    assign cap_x = (PW'(r_cap) > DEPTH_X) ? DEPTH_X : PW'(r_cap);

    assign room     = cnt_x < cap_x;
    assign in_range = pos_x < cnt_x;

    // Read port: pick the cell at the requested position.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_x == PW'(i)) begin
                rd_word = cell_q[i];
            end
        end
    end
    assign rd_x = XW'(rd_word);

    // Request decode: acceptance, cell command, the new count and the
    // response item built from them.
    always_comb begin
        ok           = 1'b0;
        cell_cmd.op  = CELL_NONE;
        cell_cmd.idx = IDX_BITS'(pos_x);
        n_count      = r_count;
        rsp_new.data = '0;
        case (i_req.data.mode)
            MODE_APPEND: begin
                ok           = room;
                cell_cmd.idx = IDX_BITS'(cnt_x);
                if (accept && ok) begin
                    cell_cmd.op = CELL_WRITE;
                    n_count     = r_count + CW'(1);
                end
            end
            MODE_INSERT: begin
                ok = room && (pos_x <= cnt_x);
                if (accept && ok) begin
                    cell_cmd.op = CELL_INSERT;
                    n_count     = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                ok = in_range;
                if (ok) begin
                    rsp_new.data = rd_x[DATA_BITS-1:0];
                end
                if (accept && ok) begin
                    cell_cmd.op = CELL_REMOVE;
                    n_count     = r_count - CW'(1);
                end
            end
            MODE_GET: begin
                ok = in_range;
                if (ok) begin
                    rsp_new.data = rd_x[DATA_BITS-1:0];
                end
            end
            MODE_SET: begin
                ok = in_range;
                if (accept && ok) begin
                    cell_cmd.op = CELL_WRITE;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        cnt_new_x        = PW'(n_count);
        rsp_new.accepted = ok;
        rsp_new.count    = cnt_new_x[COUNT_BITS-1:0];
        rsp_new.is_full  = (cnt_new_x >= cap_x);
        rsp_new.is_empty = (n_count == '0);
    end

    // The chain: each cell sees its neighbors; the ends see their own word.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = cell_q[g];
        end else begin : g_mid_l
            assign left_w = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_q[g];
        end else begin : g_mid_r
            assign right_w = cell_q[g+1];
        end

        blir_cell #(
            .IDX       (g),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_word  (in_word),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (cell_q[g])
        );
    end

    // Count and capacity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    // Response register with a one-item skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= accept;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (accept) begin
                    r_skid <= rsp_new;
                end
            end else if (accept) begin
                r_out <= rsp_new;
            end
        end else if (accept) begin
            r_skid <= rsp_new;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

@@ rtl/blir_checker.sv @@
`default_nettype none

module blir_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire        rsp_accepted,
    input wire [31:0] rsp_data,
    input wire [4:0]  rsp_count,
    input wire        rsp_is_empty
);

    // A stalled response stays valid and keeps its data and count.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_count))
        else $error("response changed while stalled");

    // The empty flag tracks the reported count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_count == 5'd0)))
        else $error("is_empty disagrees with count");

    // A rejected request returns no data.
    a_reject_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_accepted |-> rsp_data == 32'd0)
        else $error("rejected item carries data");

    // Reset drops any pending response.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind bounded_list_insert_remove_unit blir_checker u_blir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .rsp_valid    (o_rsp.valid),
    .rsp_ready    (o_rsp.ready),
    .rsp_accepted (o_rsp.data.accepted),
    .rsp_data     (o_rsp.data.data),
    .rsp_count    (o_rsp.data.count),
    .rsp_is_empty (o_rsp.data.is_empty)
);

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
    import blir_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int POS_TOP    = 2**POS_BITS - 1;
    localparam int MODE_TOP   = 2**MODE_BITS - 1;
    localparam int MAX_PRINTS = 100;

    logic i_clk;
    logic i_rst_n;

    // One channel per port of the unit: requests in, responses out, and
    // the capacity register write.
    blir_chan_if #(.T(t_req)) req_if ();
    blir_chan_if #(.T(t_rsp)) rsp_if ();
    blir_chan_if #(.T(t_cfg)) cfg_if ();

    bounded_list_insert_remove_unit #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (32)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Predicted contents of the list, updated at each accepted request.
    logic [31:0] list_words [LIST_DEPTH];
    int          list_count;
    int          list_cap;

    // Requests waiting to be driven, and responses predicted but not yet seen.
    t_req pending_reqs [$];
    t_rsp expected_rsps [$];

    // Requests queued whose response has not yet been checked. The stimulus
    // process waits on this before it touches the capacity register.
    int items_open;
    int mismatches;

    // Set at each rising edge when the request on the channel was taken.
    logic req_taken;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct;
    int take_stall_pct;

    // The stimulus keeps its own idea of the count and the capacity, only to
    // aim positions at live entries; the checking never uses it.
    int gen_count;
    int gen_cap;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Applies one request to the predicted list and returns the response
    // that the unit must give for it.
    function automatic t_rsp apply_request(t_req rq);
        t_rsp rsp;
        int   lim;
        int   pos;
        rsp = '0;
        lim = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
        pos = int'(rq.position);
        case (rq.mode)
            MODE_APPEND: begin
                if (list_count < lim) begin
                    list_words[list_count] = rq.value;
                    list_count++;
                    rsp.accepted = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (list_count < lim && pos <= list_count) begin
                    for (int i = list_count; i > pos; i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = rq.value;
                    list_count++;
                    rsp.accepted = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (pos < list_count) begin
                    rsp.data = list_words[pos];
                    for (int i = pos; i + 1 < list_count; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_count--;
                    rsp.accepted = 1'b1;
                end
            end
            MODE_GET: begin
                if (pos < list_count) begin
                    rsp.data     = list_words[pos];
                    rsp.accepted = 1'b1;
                end
            end
            MODE_SET: begin
                if (pos < list_count) begin
                    list_words[pos] = rq.value;
                    rsp.accepted    = 1'b1;
                end
            end
            default: begin
                // Unknown modes are rejected and leave the list alone.
            end
        endcase
        rsp.count    = COUNT_BITS'(list_count);
        rsp.is_full  = (list_count >= lim);
        rsp.is_empty = (list_count == 0);
        return rsp;
    endfunction

    // Monitor: everything is sampled at the rising edge. Inputs only move at
    // the falling edge, so the values seen here are the ones the unit saw.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        req_taken = req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                list_cap = int'(cfg_if.data);
            end
            // The request is predicted before the response is checked, so
            // the order in the queue stays right even for a fast response.
            if (req_taken) begin
                expected_rsps.push_back(apply_request(req_if.data));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (expected_rsps.size() == 0) begin
                    report($sformatf("response with no request outstanding: %p", got));
                end else begin
                    want = expected_rsps.pop_front();
                    items_open--;
                    if (got.accepted !== want.accepted) begin
                        report($sformatf("accepted %b, predicted %b",
                                         got.accepted, want.accepted));
                    end
                    if (got.data !== want.data) begin
                        report($sformatf("data %h, predicted %h", got.data, want.data));
                    end
                    if (got.count !== want.count) begin
                        report($sformatf("count %0d, predicted %0d", got.count, want.count));
                    end
                    if (got.is_full !== want.is_full) begin
                        report($sformatf("is_full %b, predicted %b",
                                         got.is_full, want.is_full));
                    end
                    if (got.is_empty !== want.is_empty) begin
                        report($sformatf("is_empty %b, predicted %b",
                                         got.is_empty, want.is_empty));
                    end
                end
            end
        end
    end

    // Driver: at each falling edge a new item is put on the request channel
    // once the previous one was taken, unless the sender chooses to idle.
    // The response ready is redrawn every cycle.
    always @(negedge i_clk) begin
        if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.data  <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= take_stall_pct);
    end

    task automatic queue_request(logic [MODE_BITS-1:0] mode, int pos, logic [31:0] value);
        t_req rq;
        rq.mode     = mode;
        rq.position = POS_BITS'(pos);
        rq.value    = value;
        pending_reqs.push_back(rq);
        items_open++;
        // Track the count the way the list will, to keep positions useful.
        case (mode)
            MODE_APPEND: if (gen_count < gen_cap) gen_count++;
            MODE_INSERT: if (gen_count < gen_cap && pos <= gen_count) gen_count++;
            MODE_REMOVE: if (pos < gen_count) gen_count--;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (items_open != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Capacity is only written with no request in flight.
    task automatic write_capacity(t_cfg cap);
        wait_drained();
        @(negedge i_clk);
        cfg_if.data  <= cap;
        cfg_if.valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        gen_cap = (int'(cap) > LIST_DEPTH) ? LIST_DEPTH : int'(cap);
    endtask

    // Random requests that mostly hit live positions. The count is steered
    // toward a target level that moves every few items, so the list fills,
    // drains and sits at the capacity in turn.
    task automatic queue_random_requests(int n);
        int                   target;
        int                   r;
        int                   pos;
        int                   sel;
        logic [MODE_BITS-1:0] mode;
        logic [31:0]          value;
        target = 0;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) begin
                target = $urandom_range(gen_cap);
            end
            r   = $urandom_range(99);
            pos = (gen_count > 0) ? $urandom_range(gen_count - 1) : 0;
            if (r < 6) begin
                // Noise: any mode code at any position.
                mode = MODE_BITS'($urandom_range(MODE_TOP));
                pos  = $urandom_range(POS_TOP);
            end else if (r < 12) begin
                // Growth regardless of the level, to push against a full list.
                mode = $urandom_range(1) ? MODE_APPEND : MODE_INSERT;
                pos  = $urandom_range(gen_count);
            end else if (r < 55 && gen_count < target) begin
                mode = $urandom_range(1) ? MODE_APPEND : MODE_INSERT;
                pos  = $urandom_range(gen_count);
            end else if (r < 55 && gen_count > target) begin
                mode = MODE_REMOVE;
            end else if (r < 78) begin
                mode = MODE_GET;
            end else begin
                mode = MODE_SET;
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                value = '0;
            end else if (sel == 1) begin
                value = '1;
            end else begin
                value = $urandom;
            end
            queue_request(mode, pos, value);
        end
    endtask

    // Capacity for each random chunk: reset value, saturation above the
    // depth, zero, one, and values that fall below the count left behind.
    localparam int NUM_CHUNKS = 12;
    localparam int CHUNK_CAPS [NUM_CHUNKS] = '{16, 7, 31, 1, 0, 17, 3, 12, 5, 20, 2, 9};

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        req_taken      = 1'b0;
        list_count     = 0;
        list_cap       = int'(CAP_RESET);
        items_open     = 0;
        mismatches     = 0;
        gen_count      = 0;
        gen_cap        = LIST_DEPTH;
        send_idle_pct  = 10;
        take_stall_pct = 70;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on an empty list at the reset capacity: rejections
        // on an empty list, insert at the count and past it, shifts in the
        // middle, reads at and past the last entry, and unknown modes.
        queue_request(MODE_GET,    0, 32'h0);
        queue_request(MODE_REMOVE, 0, 32'h0);
        queue_request(MODE_SET,    0, 32'h1111_1111);
        queue_request(MODE_INSERT, 1, 32'h2222_2222);
        queue_request(MODE_INSERT, 0, 32'hFFFF_FFFF);
        queue_request(MODE_APPEND, POS_TOP, 32'h0000_0000);
        queue_request(MODE_APPEND, 0, 32'hA5A5_A5A5);
        queue_request(MODE_INSERT, 3, 32'h1234_5678);
        queue_request(MODE_INSERT, POS_TOP, 32'h3333_3333);
        queue_request(MODE_INSERT, 1, 32'hDEAD_BEEF);
        queue_request(MODE_GET,    4, 32'h0);
        queue_request(MODE_GET,    5, 32'h0);
        queue_request(MODE_GET,    POS_TOP, 32'h0);
        queue_request(MODE_SET,    2, 32'h5A5A_5A5A);
        queue_request(MODE_GET,    2, 32'h0);
        queue_request(MODE_SET,    5, 32'h4444_4444);
        queue_request(MODE_REMOVE, 1, 32'h0);
        queue_request(MODE_REMOVE, POS_TOP, 32'h0);
        queue_request(MODE_REMOVE, 3, 32'h0);
        for (int m = int'(MODE_SET) + 1; m <= MODE_TOP; m++) begin
            queue_request(MODE_BITS'(m), 0, 32'hFFFF_FFFF);
        end

        // Capacity lowered below the count: growth is refused until removes
        // bring the count under the new limit.
        write_capacity(t_cfg'(2));
        queue_request(MODE_APPEND, 0, 32'h5555_5555);
        queue_request(MODE_INSERT, 0, 32'h6666_6666);
        queue_request(MODE_REMOVE, 0, 32'h0);
        queue_request(MODE_APPEND, 0, 32'h7777_7777);
        queue_request(MODE_REMOVE, 1, 32'h0);
        queue_request(MODE_APPEND, 0, 32'h8888_8888);

        // Random part. The idling pattern changes every third of the chunks:
        // a slow receiver, then a slow sender, then full throughput.
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            write_capacity(t_cfg'(CHUNK_CAPS[c]));
            if (c < NUM_CHUNKS / 3) begin
                send_idle_pct  = 10;
                take_stall_pct = 70;
            end else if (c < 2 * NUM_CHUNKS / 3) begin
                send_idle_pct  = 70;
                take_stall_pct = 10;
            end else begin
                send_idle_pct  = 0;
                take_stall_pct = 0;
            end
            queue_random_requests(70);
        end

        // Let the last responses come back, then give the unit a few more
        // cycles in case it sends something nobody asked for.
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/blir_pkg.sv
rtl/blir_chan_if.sv
rtl/blir_cell.sv
rtl/bounded_list_insert_remove_unit.sv
rtl/blir_checker.sv
tb/tb_top.sv
